@@ rtl/sfsa_pkg.sv @@
// Shared types and codes for the slot free-stack allocator.
// No dependencies; imported by slot_free_stack_allocator.
package sfsa_pkg;

  // Request kinds, carried on in_tuser
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Result status, carried on out_tuser
  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_NONE_FREE = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_UNUSED    = 3'd4
  } status_t;

  localparam int SLOT_FIELD_W = 6;
  localparam int COUNT_MAX    = 63;

endpackage

@@ rtl/slot_free_stack_allocator.sv @@
// Slot-tag allocator: LIFO free stack plus per-slot busy bits, one request per cycle.
// Depends on sfsa_pkg (status codes, request kinds).
//
// Usage:
//   in_*  channel carries requests: in_tuser = action (0 allocate, 1 release),
//         in_tdata[5:0] = slot to release (ignored for allocate).
//   out_* channel carries one result per request: out_tuser = status,
//         out_tdata[5:0] = granted slot, out_tdata[11:6] = free count after the request.
//   Slot 0 is reserved and never granted; releases of slot 0, of slots at or above
//   POOL_SLOTS, or of slots not in use are rejected with no state change.
// Path: an accepted request passes the request register, then the result register,
//   before it shows on out_tvalid.
//   Throughput: one request per cycle unless stalled, set by the single pop/push port
//   of the stack memory and the busy-bit memory read issued at request accept.
// Reset: the stack logically holds slots 1..POOL_SLOTS-1 and no slot is busy; this is
//   tracked by a low-water mark on the stack pointer, so there is no clearing pass and
//   requests are taken from the first cycle after reset.
// Stall: while out_tready is low the result holds; one more request is taken into the
//   request register, then in_tready drops until the result drains.
module slot_free_stack_allocator #(
  parameter int POOL_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [5:0] release_slot, [7:6] zero
  input  logic        in_tuser,    // [0] action
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [5:0] granted_slot, [11:6] free_count, [15:12] zero
  output logic [2:0]  out_tuser    // [2:0] status
);
  import sfsa_pkg::*;

  localparam int SW      = $clog2(POOL_SLOTS);
  localparam int CW      = $clog2(POOL_SLOTS);
  localparam int SDEPTH  = POOL_SLOTS - 1;
  localparam int IW      = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam logic [CW-1:0] TOP_RST = CW'(POOL_SLOTS - 1);

  // request register
  logic                    req_valid_r;
  logic                    req_act_r;
  logic [SLOT_FIELD_W-1:0] req_slot_r;

  // allocator state
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] lwm_r, lwm_nxt;   // lowest stack pointer ever reached

  // memories
  logic [SW-1:0] stk_mem [SDEPTH];
  logic [SW-1:0] stk_rd_r;
  logic          stk_we;
  logic [IW-1:0] stk_wa, stk_ra;
  logic [SW-1:0] stk_wd;

  logic          busy_mem [POOL_SLOTS];
  logic          busy_rd_r;
  logic          busy_we;
  logic [SW-1:0] busy_wa;
  logic          busy_wd;

  // result register
  logic        out_valid_r;
  logic [15:0] out_tdata_r;
  logic [2:0]  out_tuser_r;

  logic          in_acc, out_can, fire;
  logic [SW-1:0] in_slot_ext, slot_ext, pop_slot;
  logic          in_range, busy_ok;
  status_t       status;
  logic [SLOT_FIELD_W-1:0] granted, count_sat;

  assign out_can     = !out_valid_r || out_tready;
  assign in_tready   = !req_valid_r || out_can;
  assign in_acc      = in_tvalid && in_tready;
  assign fire        = req_valid_r && out_can;
  assign in_slot_ext = SW'(in_tdata[SLOT_FIELD_W-1:0]);
  assign slot_ext    = SW'(req_slot_r);

  // entries below the low-water mark were never written and still hold index+1
  assign pop_slot = (top_r <= lwm_r) ? SW'(top_r) : stk_rd_r;
  assign in_range = (req_slot_r != '0) && (int'(req_slot_r) < POOL_SLOTS);
  // slots at or below the low-water mark were never granted
  assign busy_ok  = busy_rd_r && (slot_ext > SW'(lwm_r));

  always_comb begin
    top_nxt = top_r;
    lwm_nxt = lwm_r;
    stk_we  = 1'b0;
    stk_wa  = IW'(top_r);
    stk_wd  = slot_ext;
    busy_we = 1'b0;
    busy_wa = pop_slot;
    busy_wd = 1'b1;
    granted = '0;
    status  = ST_NONE_FREE;
    if (req_act_r == ACT_ALLOC) begin
      if (top_r == '0) begin
        status = ST_NONE_FREE;
      end else begin
        status  = ST_ALLOCATED;
        granted = SLOT_FIELD_W'(pop_slot);
        if (fire) begin
          top_nxt = top_r - CW'(1);
          if ((top_r - CW'(1)) < lwm_r) begin
            lwm_nxt = top_r - CW'(1);
          end
          busy_we = 1'b1;
        end
      end
    end else begin
      if (!in_range) begin
        status = ST_RANGE;
      end else if (!busy_ok) begin
        status = ST_UNUSED;
      end else begin
        status = ST_RELEASED;
        if (fire) begin
          busy_we = 1'b1;
          busy_wa = slot_ext;
          busy_wd = 1'b0;
          stk_we  = 1'b1;
          top_nxt = top_r + CW'(1);
        end
      end
    end
    // prefetch the entry under the next stack pointer
    stk_ra = IW'(top_nxt - CW'(1));
  end

  assign count_sat = (int'(top_nxt) > COUNT_MAX) ? SLOT_FIELD_W'(COUNT_MAX)
                                                 : SLOT_FIELD_W'(top_nxt);

  // stack memory, write-first on a same-cycle push and prefetch
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_we && (stk_wa == stk_ra)) begin
      stk_rd_r <= stk_wd;
    end else begin
      stk_rd_r <= stk_mem[stk_ra];
    end
  end

  // busy-bit memory, read at request accept with forwarding from the request in flight
  always_ff @(posedge clk) begin
    if (busy_we) begin
      busy_mem[busy_wa] <= busy_wd;
    end
    if (in_acc) begin
      if (busy_we && (busy_wa == in_slot_ext)) begin
        busy_rd_r <= busy_wd;
      end else begin
        busy_rd_r <= busy_mem[in_slot_ext];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      top_r       <= TOP_RST;
      lwm_r       <= TOP_RST;
    end else begin
      top_r <= top_nxt;
      lwm_r <= lwm_nxt;
      if (in_acc) begin
        req_valid_r <= 1'b1;
      end else if (fire) begin
        req_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_act_r  <= in_tuser;
      req_slot_r <= in_tdata[SLOT_FIELD_W-1:0];
    end
    if (fire) begin
      out_tdata_r <= {4'b0000, count_sat, granted};
      out_tuser_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // checks
  a_lwm_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    lwm_r <= top_r) else $error("low-water mark above stack pointer");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(top_r) <= POOL_SLOTS - 1) else $error("stack pointer beyond pool");

  a_pop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && status == ST_ALLOCATED) |-> (pop_slot != '0))
    else $error("reserved slot granted");

  a_push_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && status == ST_RELEASED) |=> (top_r == $past(top_r) + CW'(1)))
    else $error("release did not push");

  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (status == ST_RANGE || status == ST_UNUSED || status == ST_NONE_FREE))
    |=> (top_r == $past(top_r))) else $error("rejected request changed stack");

endmodule
